// ===== rtl/core/move_to_front_list_defines.svh =====
// Assertion macros for the move-to-front list
`ifndef MOVE_TO_FRONT_LIST_DEFINES_SVH
`define MOVE_TO_FRONT_LIST_DEFINES_SVH

`ifndef SYNTHESIS
`define MTF_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define MTF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MTF_ASSERT(lbl, ante, cons, msg)
`define MTF_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/core/mtf_pkg.sv =====
// Package with types and constants of the move-to-front list
`timescale 1ns / 1ps
package mtf_pkg;

  localparam int unsigned MtfDepth = 64;
  localparam int unsigned MinCap   = 5;
  localparam int unsigned CapReset = 64;
  localparam int unsigned CapW     = 7;
  localparam int unsigned ValW     = 32;
  localparam int unsigned StW      = 2;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_FIND   = 1'b1
  } cmd_e;

  typedef enum logic [StW-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2
  } status_e;

  typedef struct packed {
    logic shift_all;
    logic apply;
    logic clear;
  } mtf_ctl_t;

endpackage

// ===== rtl/core/mtf_in_if.sv =====
// Input channel carrying command and value
`timescale 1ns / 1ps
interface mtf_in_if;
  logic                              valid;
  logic                              ready;
  logic                              cmd;
  logic signed [mtf_pkg::ValW-1:0]   value;

  modport source (output valid, cmd, value, input ready);
  modport sink   (input valid, cmd, value, output ready);
endinterface

// ===== rtl/core/mtf_out_if.sv =====
// Output channel carrying status and count
`timescale 1ns / 1ps
interface mtf_out_if;
  logic                       valid;
  logic                       ready;
  logic [mtf_pkg::StW-1:0]    status;
  logic [mtf_pkg::CapW-1:0]   count;

  modport source (output valid, status, count, input ready);
  modport sink   (input valid, status, count, output ready);
endinterface

// ===== rtl/core/mtf_cell.sv =====
// One list cell: holds an entry, compares under the probe, shifts from its neighbor
`timescale 1ns / 1ps
module mtf_cell (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  mtf_pkg::mtf_ctl_t                ctl_i,
  input  logic signed [mtf_pkg::ValW-1:0]  key_i,
  input  logic signed [mtf_pkg::ValW-1:0]  prev_val_i,
  input  logic                             prev_probe_i,
  output logic signed [mtf_pkg::ValW-1:0]  val_o,
  output logic                             probe_o,
  output logic                             match_o
);
  import mtf_pkg::*;

  logic signed [ValW-1:0] val_q;
  logic                   probe_q, probe_d;
  logic                   visited_q, visited_d;
  logic                   load;

  assign match_o   = probe_q & (val_q == key_i);
  assign probe_o   = probe_q & ~match_o;
  assign val_o     = val_q;
  assign probe_d   = ctl_i.clear ? 1'b0 : prev_probe_i;
  assign visited_d = ctl_i.clear ? 1'b0 : (visited_q | probe_q);
  assign load      = ctl_i.shift_all | (ctl_i.apply & (visited_q | probe_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_q   <= 1'b0;
      visited_q <= 1'b0;
    end else begin
      probe_q   <= probe_d;
      visited_q <= visited_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      val_q <= prev_val_i;
    end
  end

endmodule

// ===== rtl/core/move_to_front_list.sv =====
// Top level of the move-to-front list: control, result queue and cell chain
`timescale 1ns / 1ps
`include "move_to_front_list_defines.svh"

// Move-to-front list of signed 32-bit values held in a chain of DEPTH cells, front at
// cell 0. An insert into a list that is not full has every cell load its neighbor's
// entry in the cycle of the transaction; inserts stream at one per cycle while the
// result queue has room. A find sends a probe down the chain one cell per cycle; on a
// hit the cells the probe passed shift back and the value lands at the front in the
// same cycle that the scan ends; a miss ends at the last entry, a find on an empty list
// at once. After a scan the next transaction is taken once the queue has room. Capacity
// is clamped to 5..DEPTH. Results pass through a two-entry queue, so the input keeps
// moving while one result waits on the output. No clearing pass follows reset.
module move_to_front_list #(
  parameter int unsigned DEPTH = mtf_pkg::MtfDepth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [mtf_pkg::CapW-1:0]    cfg_wdata_i,
  mtf_in_if.sink                      in_i,
  mtf_out_if.source                   out_o
);
  import mtf_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned CmpW = (CntW > CapW) ? CntW : CapW;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_e;

  state_e                 state_q;
  logic [CntW-1:0]        count_q, count_d;
  logic [CntW-1:0]        k_q;
  logic signed [ValW-1:0] key_q;
  logic [CapW-1:0]        cap_q;
  logic                   out_vld_q, pend_vld_q;
  status_e                out_st_q, pend_st_q;
  logic [CapW-1:0]        out_cnt_q, pend_cnt_q;

  logic                   in_hs, out_free, full, last, any_match, start;
  logic                   res_vld;
  status_e                res_st;
  logic [CapW-1:0]        res_cnt;
  logic [CmpW-1:0]        cap_ext, eff_cap;
  logic signed [ValW-1:0] head_val;
  mtf_ctl_t               ctl;

  logic signed [ValW-1:0] val_w   [DEPTH];
  logic                   probe_w [DEPTH];
  logic [DEPTH-1:0]       match;

  assign in_i.ready   = (state_q == S_IDLE) & ~pend_vld_q;
  assign in_hs        = in_i.valid & in_i.ready;
  assign out_free     = ~out_vld_q | out_o.ready;
  assign out_o.valid  = out_vld_q;
  assign out_o.status = out_st_q;
  assign out_o.count  = out_cnt_q;

  assign cap_ext   = CmpW'(cap_q);
  assign eff_cap   = (cap_ext < CmpW'(MinCap)) ? CmpW'(MinCap) :
                     (cap_ext > CmpW'(DEPTH))  ? CmpW'(DEPTH)  : cap_ext;
  assign full      = CmpW'(count_q) >= eff_cap;
  assign last      = (k_q + CntW'(1)) == count_q;
  assign any_match = |match;
  assign head_val  = (state_q == S_SCAN) ? key_q : in_i.value;
  assign count_d   = ctl.shift_all ? (count_q + CntW'(1)) : count_q;
  assign res_cnt   = CapW'(count_d);

  always_comb begin
    ctl     = '0;
    start   = 1'b0;
    res_vld = 1'b0;
    res_st  = ST_OK;
    if (in_hs) begin
      if (in_i.cmd == CMD_INSERT) begin
        res_vld = 1'b1;
        if (full) begin
          res_st = ST_FULL;
        end else begin
          ctl.shift_all = 1'b1;
        end
      end else if (count_q == '0) begin
        res_vld = 1'b1;
        res_st  = ST_MISS;
      end else begin
        start = 1'b1;
      end
    end
    if (state_q == S_SCAN) begin
      if (any_match) begin
        ctl.apply = 1'b1;
        ctl.clear = 1'b1;
        res_vld   = 1'b1;
      end else if (last) begin
        ctl.clear = 1'b1;
        res_vld   = 1'b1;
        res_st    = ST_MISS;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      count_q    <= '0;
      k_q        <= '0;
      key_q      <= '0;
      cap_q      <= CapW'(CapReset);
      out_vld_q  <= 1'b0;
      out_st_q   <= ST_OK;
      out_cnt_q  <= '0;
      pend_vld_q <= 1'b0;
      pend_st_q  <= ST_OK;
      pend_cnt_q <= '0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      count_q <= count_d;
      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            state_q <= S_SCAN;
            k_q     <= '0;
            key_q   <= in_i.value;
          end
        end
        S_SCAN: begin
          if (ctl.clear) begin
            state_q <= S_IDLE;
          end else begin
            k_q <= k_q + CntW'(1);
          end
        end
      endcase
      if (res_vld) begin
        if (out_free) begin
          out_vld_q <= 1'b1;
          out_st_q  <= res_st;
          out_cnt_q <= res_cnt;
        end else begin
          pend_vld_q <= 1'b1;
          pend_st_q  <= res_st;
          pend_cnt_q <= res_cnt;
        end
      end else if (out_free) begin
        out_vld_q <= pend_vld_q;
        if (pend_vld_q) begin
          out_st_q   <= pend_st_q;
          out_cnt_q  <= pend_cnt_q;
          pend_vld_q <= 1'b0;
        end
      end
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [ValW-1:0] prev_val;
    logic                   prev_probe;
    if (i == 0) begin : g_head
      assign prev_val   = head_val;
      assign prev_probe = start;
    end else begin : g_body
      assign prev_val   = val_w[i-1];
      assign prev_probe = probe_w[i-1];
    end
    mtf_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .key_i        (key_q),
      .prev_val_i   (prev_val),
      .prev_probe_i (prev_probe),
      .val_o        (val_w[i]),
      .probe_o      (probe_w[i]),
      .match_o      (match[i])
    );
  end

  `MTF_ASSERT(a_cnt_bound, 1'b1, count_q <= CntW'(DEPTH), "count exceeds depth")
  `MTF_ASSERT(a_one_probe, state_q == S_SCAN, $onehot0(match), "more than one cell matched")
  `MTF_ASSERT(a_no_overrun, res_vld, !pend_vld_q, "result produced while queue full")
  `MTF_ASSERT_NXT(a_ins_cnt, in_hs && in_i.cmd == CMD_INSERT && !full,
                  count_q == $past(count_q) + CntW'(1), "insert did not advance count")

endmodule
